// File: src/tdt_pkg.sv
// ----------------------------------------------------------------------------
// tdt_pkg: shared types and constants for the tile dedup table
// Table size, index widths, outcome codes and controller/datapath bundles.
// ----------------------------------------------------------------------------
package tdt_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int HALF_W        = 64;
  localparam int SLOT_W        = 8;

  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_ENTRIES);

  typedef enum logic [1:0] {
    OUTCOME_FOUND = 2'd0,
    OUTCOME_ADDED = 2'd1,
    OUTCOME_FULL  = 2'd2
  } outcome_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic take_hit;
    logic take_end;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic scan_end;
  } status_t;

endpackage

// File: src/tdt_tile_if.sv
// ----------------------------------------------------------------------------
// tdt_tile_if: tile input channel
// One beat carries both 64-bit halves of a 16-byte tile.
// ----------------------------------------------------------------------------
interface tdt_tile_if;
  logic                        valid;
  logic                        ready;
  logic [tdt_pkg::HALF_W-1:0]  tile_low_half;
  logic [tdt_pkg::HALF_W-1:0]  tile_high_half;

  modport source (output valid, output tile_low_half, output tile_high_half, input ready);
  modport sink   (input valid, input tile_low_half, input tile_high_half, output ready);
endinterface

// File: src/tdt_slot_if.sv
// ----------------------------------------------------------------------------
// tdt_slot_if: result channel
// One beat carries the slot index and the lookup outcome.
// ----------------------------------------------------------------------------
interface tdt_slot_if;
  logic                        valid;
  logic                        ready;
  logic [tdt_pkg::SLOT_W-1:0]  slot_index;
  logic [1:0]                  outcome;

  modport source (output valid, output slot_index, output outcome, input ready);
  modport sink   (input valid, input slot_index, input outcome, output ready);
endinterface

// File: src/tdt_ctrl.sv
// ----------------------------------------------------------------------------
// tdt_ctrl: lookup controller
// Sequences load, scan and result hand-off; owns the handshake flags.
// ----------------------------------------------------------------------------
module tdt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  tdt_pkg::status_t  status,
  output tdt_pkg::cmd_t     cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next   = state;
    cmd          = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (status.hit) begin
          cmd.take_hit = 1'b1;
          state_next   = S_DONE;
        end else if (status.scan_end) begin
          cmd.take_end = 1'b1;
          state_next   = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.publish) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

// File: src/tdt_datapath.sv
// ----------------------------------------------------------------------------
// tdt_datapath: tile store, scan pipeline and result registers
// One store read per cycle, compare on the registered read data.
// ----------------------------------------------------------------------------
module tdt_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  tdt_pkg::cmd_t               cmd,
  output tdt_pkg::status_t            status,
  input  logic [tdt_pkg::HALF_W-1:0]  tile_low_half,
  input  logic [tdt_pkg::HALF_W-1:0]  tile_high_half,
  output logic [tdt_pkg::SLOT_W-1:0]  slot_index,
  output tdt_pkg::outcome_t           outcome
);

  logic [2*tdt_pkg::HALF_W-1:0] store [tdt_pkg::TABLE_ENTRIES];

  logic [2*tdt_pkg::HALF_W-1:0] tile;
  logic [2*tdt_pkg::HALF_W-1:0] rd_data;
  logic [tdt_pkg::CNT_W-1:0]    addr;
  logic [tdt_pkg::CNT_W-1:0]    fill_count;
  logic [tdt_pkg::IDX_W-1:0]    rd_idx;
  logic                         rd_vld;
  logic [tdt_pkg::IDX_W-1:0]    res_idx;
  tdt_pkg::outcome_t            res_outcome;
  logic                         more;
  logic                         issue;
  logic [tdt_pkg::IDX_W+tdt_pkg::SLOT_W-1:0] slot_ext;

  assign more  = addr < fill_count;
  assign issue = cmd.scan && more;

  assign status.hit      = rd_vld && (rd_data == tile);
  assign status.scan_end = !more && !rd_vld;

  always_ff @(posedge clk) begin
    if (issue) rd_data <= store[addr[tdt_pkg::IDX_W-1:0]];
    if (cmd.take_end && fill_count != tdt_pkg::FULL_COUNT)
      store[fill_count[tdt_pkg::IDX_W-1:0]] <= tile;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      rd_vld     <= 1'b0;
      addr       <= '0;
    end else begin
      if (cmd.load) begin
        addr   <= '0;
        rd_vld <= 1'b0;
      end else if (cmd.scan) begin
        rd_vld <= issue;
        if (issue) addr <= addr + tdt_pkg::CNT_W'(1);
      end
      if (cmd.take_end && fill_count != tdt_pkg::FULL_COUNT)
        fill_count <= fill_count + tdt_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) tile <= {tile_high_half, tile_low_half};
    if (issue) rd_idx <= addr[tdt_pkg::IDX_W-1:0];
    if (cmd.take_hit) begin
      res_idx     <= rd_idx;
      res_outcome <= tdt_pkg::OUTCOME_FOUND;
    end else if (cmd.take_end) begin
      if (fill_count == tdt_pkg::FULL_COUNT) begin
        res_idx     <= '0;
        res_outcome <= tdt_pkg::OUTCOME_FULL;
      end else begin
        res_idx     <= fill_count[tdt_pkg::IDX_W-1:0];
        res_outcome <= tdt_pkg::OUTCOME_ADDED;
      end
    end
  end

  assign slot_ext = {{tdt_pkg::SLOT_W{1'b0}}, res_idx};

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      slot_index <= slot_ext[tdt_pkg::SLOT_W-1:0];
      outcome    <= res_outcome;
    end
  end

endmodule

// File: src/tile_dedup_table_unit.sv
// ----------------------------------------------------------------------------
// tile_dedup_table_unit: deduplicating 16-byte tile table
// Looks a tile up in insertion order and appends it when it is new and the table is not full.
// ----------------------------------------------------------------------------
// One tile is handled at a time. After a tile beat is accepted the store is
// read one entry per cycle from index 0, until a match or the end of the filled
// entries; the single read port of the tile store sets this pace.
// The result sits in an output register, so the next tile is taken while a
// result waits; a finished lookup holds until that register is free.
// slot_index is zero on a full outcome.
// The store has no reset; only entries below the fill count are ever read.
module tile_dedup_table_unit (
  input  logic       clk,
  input  logic       rst,
  tdt_tile_if.sink   tiles,
  tdt_slot_if.source slots
);

  tdt_pkg::cmd_t     cmd;
  tdt_pkg::status_t  status;
  tdt_pkg::outcome_t outcome;

  tdt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (tiles.valid),
    .in_ready  (tiles.ready),
    .out_valid (slots.valid),
    .out_ready (slots.ready),
    .status    (status),
    .cmd       (cmd)
  );

  tdt_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .tile_low_half  (tiles.tile_low_half),
    .tile_high_half (tiles.tile_high_half),
    .slot_index     (slots.slot_index),
    .outcome        (outcome)
  );

  assign slots.outcome = outcome;

endmodule

// File: src/tdt_checker.sv
// ----------------------------------------------------------------------------
// tdt_checker: port-level assertions for the tile dedup table
// Watches the result channel and the one-tile-at-a-time input behavior.
// ----------------------------------------------------------------------------
module tdt_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [tdt_pkg::SLOT_W-1:0]  slot_index,
  input logic [1:0]                  outcome
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(slot_index) && $stable(outcome))
    else $error("stalled result beat changed");

  a_outcome_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> outcome == tdt_pkg::OUTCOME_FOUND || outcome == tdt_pkg::OUTCOME_ADDED
                  || outcome == tdt_pkg::OUTCOME_FULL)
    else $error("unknown outcome code");

  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && outcome == tdt_pkg::OUTCOME_FULL |-> slot_index == '0)
    else $error("full outcome with nonzero slot");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second tile taken during a lookup");

endmodule

bind tile_dedup_table_unit tdt_checker u_tdt_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (tiles.valid),
  .in_ready   (tiles.ready),
  .out_valid  (slots.valid),
  .out_ready  (slots.ready),
  .slot_index (slots.slot_index),
  .outcome    (slots.outcome)
);
